>>> sv/src_pkg.sv
// Shared types and constants for the stepper ramp controller.
package src_pkg;

  // Item kinds carried in s_tuser
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SWITCH = 2'd1,
    OP_START  = 2'd2,
    OP_MOTION = 2'd3
  } op_t;

  // Direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;
  localparam logic [1:0] DIR_BAD  = 2'd3;

  // Ramp codes; the unused fourth code is stored and leaves the period alone
  localparam logic [1:0] RAMP_ACC = 2'd0;
  localparam logic [1:0] RAMP_DEC = 2'd1;
  localparam logic [1:0] RAMP_UNI = 2'd2;

  // Switch levels
  localparam logic SW_PRESSED = 1'b0;

  localparam logic [7:0] ACCEL_FLOOR  = 8'h20;
  localparam logic [7:0] DECEL_CEIL   = 8'h60;
  localparam logic [7:0] PERIOD_RESET = 8'h80;

  // Coil pattern reset values, phase zero in the low nibble
  localparam logic [3:0][3:0] PATTERN_RESET = {4'h8, 4'h4, 4'h2, 4'h1};

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  typedef logic [3:0][3:0] pattern_set_t;

  typedef struct packed {
    op_t        operation;
    logic       switch_level;
    logic [1:0] new_direction;
    logic [1:0] new_ramp;
  } item_t;

  typedef struct packed {
    logic [7:0]  period_now;
    logic [1:0]  motion;
    logic [15:0] steps_done;
    logic        step_taken;
    logic [3:0]  coil_drive;
  } result_t;

endpackage

>>> sv/src_core.sv
// Motor state registers and the per-item next-state logic.
module src_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  src_pkg::item_t        item,
  input  src_pkg::pattern_set_t patterns,
  output src_pkg::result_t      result
);
  import src_pkg::*;

  localparam int TOTAL_BITS = (COUNT_BITS >= 16) ? 16 : COUNT_BITS;

  logic [7:0]            tick_count, tick_count_next;
  logic [7:0]            step_period, step_period_next;
  logic [1:0]            phase_index, phase_index_next;
  logic [1:0]            move_dir, move_dir_next;
  logic [1:0]            ramp_mode, ramp_mode_next;
  logic [TOTAL_BITS-1:0] step_total, step_total_next;
  logic [3:0]            coil_hold, coil_hold_next;
  logic                  stepped;
  logic                  moving_next;
  logic [7:0]            tick_inc;

  assign tick_inc = tick_count + 8'd1;

  always_comb begin
    tick_count_next  = tick_count;
    step_period_next = step_period;
    phase_index_next = phase_index;
    move_dir_next    = move_dir;
    ramp_mode_next   = ramp_mode;
    step_total_next  = step_total;
    coil_hold_next   = coil_hold;
    stepped          = 1'b0;

    case (item.operation)
      OP_TICK: begin
        tick_count_next = tick_inc;
        if (tick_inc >= step_period) begin
          tick_count_next = 8'd0;
          case (ramp_mode)
            RAMP_ACC: begin
              if (step_period >= ACCEL_FLOOR) step_period_next = step_period - 8'd1;
            end
            RAMP_DEC: begin
              if (step_period <= DECEL_CEIL) step_period_next = step_period + 8'd1;
              else move_dir_next = DIR_STOP;
            end
            RAMP_UNI: step_period_next = DECEL_CEIL;
            default: ;
          endcase
          coil_hold_next = 4'd0;
          if (move_dir_next == DIR_DOWN) begin
            if (step_total != {TOTAL_BITS{1'b1}})
              step_total_next = step_total + TOTAL_BITS'(1);
            coil_hold_next   = patterns[phase_index];
            phase_index_next = phase_index + 2'd1;
            stepped          = 1'b1;
          end else if (move_dir_next == DIR_UP) begin
            // up walks the patterns in reverse order
            coil_hold_next   = patterns[~phase_index];
            phase_index_next = phase_index + 2'd1;
            stepped          = 1'b1;
          end
        end
      end
      OP_SWITCH: begin
        if (item.switch_level == SW_PRESSED) begin
          if (move_dir == DIR_UP) begin
            move_dir_next  = DIR_DOWN;
            ramp_mode_next = RAMP_ACC;
          end else if (move_dir == DIR_DOWN) begin
            move_dir_next  = DIR_UP;
            ramp_mode_next = RAMP_ACC;
          end
        end else begin
          move_dir_next = DIR_STOP;
        end
      end
      OP_START: begin
        if (move_dir != DIR_UP && move_dir != DIR_DOWN) begin
          move_dir_next   = DIR_UP;
          ramp_mode_next  = RAMP_ACC;
          step_total_next = '0;
        end
      end
      OP_MOTION: begin
        move_dir_next  = (item.new_direction == DIR_BAD) ? DIR_STOP : item.new_direction;
        ramp_mode_next = item.new_ramp;
      end
      default: ;
    endcase

    if (move_dir_next != DIR_UP && move_dir_next != DIR_DOWN) move_dir_next = DIR_STOP;
  end

  assign moving_next = (move_dir_next == DIR_UP) || (move_dir_next == DIR_DOWN);

  always_comb begin
    result.coil_drive = moving_next ? coil_hold_next : 4'd0;
    result.step_taken = stepped;
    result.steps_done = 16'(step_total_next);
    result.motion     = move_dir_next;
    result.period_now = step_period_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= 8'd0;
      step_period <= PERIOD_RESET;
      phase_index <= 2'd0;
      move_dir    <= DIR_DOWN;
      ramp_mode   <= RAMP_ACC;
      step_total  <= '0;
      coil_hold   <= 4'd0;
    end else if (advance) begin
      tick_count  <= tick_count_next;
      step_period <= step_period_next;
      phase_index <= phase_index_next;
      move_dir    <= move_dir_next;
      ramp_mode   <= ramp_mode_next;
      step_total  <= step_total_next;
      coil_hold   <= coil_hold_next;
    end
  end

endmodule

>>> sv/stepper_ramp_controller_top.sv
// Top level of the stepper ramp controller: input register, core, result register.
//
// Usage:
//   Items enter on the s_ channel: s_tuser carries the item kind (timer tick,
//   limit switch change, start run, set motion) and s_tdata the switch level,
//   new direction and new ramp. Every item gives exactly one result on the m_
//   channel: coil nibble, step flag, saturating downward step count, direction
//   and current step period.
//   The four coil patterns are written through cfg_we / cfg_index / cfg_data,
//   one nibble per write, while no item is in flight.
//   Path: an accepted item is registered in the input register, processed through
//   the core's next-state logic, and its result is loaded into the result
//   register when the result register is free or draining.
//   Throughput: one item per cycle while m_tready is high; the single input
//   register and the single result register each refill in the cycle they drain.
//   Reset (rst, synchronous): the period returns to 128, direction to down,
//   ramp to accelerate, counts and coil hold to zero, and the coil patterns to
//   wave drive 1, 2, 4, 8; both registers are emptied.
//   Stall: while m_tready is low the result holds, the item behind it waits in
//   the input register, and s_tready drops only when both are full.
module stepper_ramp_controller_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [0] switch_level, [2:1] new_direction, [4:3] new_ramp, [7:5] zero
  input  logic [src_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] operation
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [3:0] coil_drive, [4] step_taken, [20:5] steps_done, [22:21] motion,
  // [30:23] period_now, [31] zero
  output logic [src_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [3:0]                     cfg_data
);
  import src_pkg::*;

  logic         in_valid;
  item_t        in_item;
  logic         advance;
  pattern_set_t patterns;
  result_t      result;
  result_t      out_result;

  // Process the held item whenever the result register is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Capture the item payload on acceptance
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.operation     <= op_t'(s_tuser);
      in_item.switch_level  <= s_tdata[0];
      in_item.new_direction <= s_tdata[2:1];
      in_item.new_ramp      <= s_tdata[4:3];
    end
  end

  // Coil pattern registers
  always_ff @(posedge clk) begin
    if (rst) begin
      patterns <= PATTERN_RESET;
    end else if (cfg_we) begin
      patterns[cfg_index] <= cfg_data;
    end
  end

  src_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .patterns(patterns),
    .result  (result)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_result <= result;
  end

  assign m_tdata = {1'b0, out_result};

endmodule

>>> sv/src_checker.sv
// Port-level checker for the stepper ramp controller and its bind.
module src_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  import src_pkg::*;

  // Result channel is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Direction is never the unused code
  a_motion_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[22:21] != DIR_BAD)
    else $error("unused direction code on output");

  // Coils are dark while stopped
  a_stop_dark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[22:21] == DIR_STOP |-> m_tdata[3:0] == 4'd0)
    else $error("coils driven while stopped");

  // A step only happens while moving
  a_step_moving: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[22:21] == DIR_UP || m_tdata[22:21] == DIR_DOWN)
    else $error("step reported while stopped");

endmodule

bind stepper_ramp_controller_top src_checker u_src_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
